/* design/chained_hash_table_engine_core_macros.svh */
// Assertion macros for the chained hash table engine checker
`ifndef CHAINED_HASH_TABLE_ENGINE_CORE_MACROS_SVH
`define CHAINED_HASH_TABLE_ENGINE_CORE_MACROS_SVH

// antecedent holds, consequent in the same cycle
`define CHT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("chained hash table check failed");

// antecedent holds, consequent in the next cycle
`define CHT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("chained hash table check failed");

`endif

/* design/cht_pkg.sv */
// Types, constants and helpers shared by the chained hash table engine
package cht_pkg;

    localparam int CHT_ITEM_CAPACITY = 256;
    localparam int CHT_MAX_BUCKETS   = 512;
    localparam int CHT_INIT_BUCKETS  = 1;
    localparam int CHT_KEY_BYTES     = 8;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_NEXT   = 2'd2,
        CMD_FIRST  = 2'd3
    } cht_cmd_t;

    typedef enum logic [1:0] {
        STAT_OK   = 2'd0,
        STAT_MISS = 2'd1,
        STAT_FULL = 2'd2
    } cht_status_t;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_START,
        S_INS,
        S_RH_CLR,
        S_RH_RD,
        S_RH_HASH,
        S_RH_LINK,
        S_F_HEAD,
        S_F_CHK,
        S_F_CMP,
        S_RM_LAST,
        S_RM_LREC,
        S_RM_LHEAD,
        S_RM_WCHK,
        S_RM_WNXT,
        S_RM_COPY,
        S_FF_CHK,
        S_FF_RD,
        S_VAL,
        S_DONE
    } cht_state_t;

    typedef struct packed {
        logic [63:0] key;
        logic [3:0]  len;
        logic [63:0] value;
        logic [31:0] hash;
    } cht_rec_t;

    // log2 of the initial bucket count, rounded down and held to the maximum
    function automatic int init_log2(input int init_b, input int max_b);
        int lg;
        lg = 0;
        while (((2 << lg) <= init_b) && ((2 << lg) <= max_b))
            lg = lg + 1;
        return lg;
    endfunction

endpackage

/* design/cht_ram.sv */
// Generic single write, single read RAM with registered read data
module cht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* design/chained_hash_table_engine_core.sv */
// Top level of the chained hash table engine: sequencer, item and bucket stores
//
//  channel | words                                             | handshake
//  --------+---------------------------------------------------+-----------------------
//  in      | command key_bytes key_length hash_value           | in_valid / in_stall
//          | data_value origin_bucket                          |
//  out     | status item_index result_value                    | out_valid / out_stall
//
// Each word walks the stores one RAM read per step: insert writes the record, its
// link and the bucket head; lookups follow the chain link by link; bucket scans
// step over empty buckets; remove adds a walk of the moved item's chain; growth
// relinks every item. After reset a clearing pass empties the bucket heads.
// in_stall is high from acceptance until the result is loaded into the output
// register; a stalled result holds and the next word may be accepted behind it.
module chained_hash_table_engine_core #(
    parameter int ITEM_CAPACITY = cht_pkg::CHT_ITEM_CAPACITY,
    parameter int MAX_BUCKETS   = cht_pkg::CHT_MAX_BUCKETS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  command,
    input  logic [63:0] key_bytes,
    input  logic [3:0]  key_length,
    input  logic [31:0] hash_value,
    input  logic [63:0] data_value,
    input  logic [9:0]  origin_bucket,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [7:0]  item_index,
    output logic [63:0] result_value
);

    import cht_pkg::*;

    localparam int IW = $clog2(ITEM_CAPACITY);
    localparam int PW = IW + 1;
    localparam int BW = $clog2(MAX_BUCKETS);
    localparam int LW = $clog2(BW + 1);
    localparam int SW = (BW + 1 > 10) ? BW + 1 : 10;
    localparam int RW = $bits(cht_rec_t);
    localparam logic [PW-1:0] NIL = {PW{1'b1}};
    localparam logic [LW-1:0] LG_INIT = LW'(init_log2(CHT_INIT_BUCKETS, MAX_BUCKETS));

    cht_state_t  state_reg, state_next;
    cht_cmd_t    cmd_reg, cmd_next;
    logic [63:0] key_reg, key_next;
    logic [3:0]  len_reg, len_next;
    logic [31:0] hash_reg, hash_next;
    logic [63:0] data_reg, data_next;
    logic [9:0]  start_reg, start_next;
    logic [BW-1:0] bkt_reg, bkt_next;
    logic [PW-1:0] count_reg, count_next;
    logic [LW-1:0] lg_reg, lg_next;
    logic [PW-1:0] cur_reg, cur_next;
    logic [PW-1:0] prev_reg, prev_next;
    logic [PW-1:0] idx_reg, idx_next;
    logic [SW-1:0] scan_reg, scan_next;
    cht_rec_t      lrec_reg, lrec_next;
    logic [PW-1:0] lnext_reg, lnext_next;
    cht_status_t   res_status_reg, res_status_next;
    logic [PW-1:0] res_index_reg, res_index_next;
    logic [63:0]   res_value_reg, res_value_next;
    logic          out_valid_reg, out_valid_next;
    cht_status_t   out_status_reg, out_status_next;
    logic [7:0]    out_index_reg, out_index_next;
    logic [63:0]   out_value_reg, out_value_next;

    logic          h_we;
    logic [BW-1:0] h_waddr, h_raddr;
    logic [PW-1:0] h_wdata, h_rdata;
    logic          n_we;
    logic [IW-1:0] n_waddr, n_raddr;
    logic [PW-1:0] n_wdata, n_rdata;
    logic          r_we;
    logic [IW-1:0] r_waddr, r_raddr;
    cht_rec_t      r_wdata, r_rdata;
    logic [RW-1:0] r_rdata_raw;

    logic [BW:0]   nb;
    logic [BW-1:0] bmask;
    logic [PW-1:0] last;
    logic [3:0]    len_c;
    logic [63:0]   key_m;
    logic          grow;
    logic          match;

    cht_ram #(.WIDTH(PW), .DEPTH(MAX_BUCKETS)) u_heads (
        .clk   (clk),
        .we    (h_we),
        .waddr (h_waddr),
        .wdata (h_wdata),
        .raddr (h_raddr),
        .rdata (h_rdata)
    );

    cht_ram #(.WIDTH(PW), .DEPTH(ITEM_CAPACITY)) u_next (
        .clk   (clk),
        .we    (n_we),
        .waddr (n_waddr),
        .wdata (n_wdata),
        .raddr (n_raddr),
        .rdata (n_rdata)
    );

    cht_ram #(.WIDTH(RW), .DEPTH(ITEM_CAPACITY)) u_recs (
        .clk   (clk),
        .we    (r_we),
        .waddr (r_waddr),
        .wdata (r_wdata),
        .raddr (r_raddr),
        .rdata (r_rdata_raw)
    );

    assign r_rdata = cht_rec_t'(r_rdata_raw);

    assign nb    = (BW + 1)'(1) << lg_reg;
    assign bmask = BW'(nb - (BW + 1)'(1));
    assign last  = count_reg - PW'(1);
    assign len_c = (key_length > 4'(CHT_KEY_BYTES)) ? 4'(CHT_KEY_BYTES) : key_length;
    assign grow  = ((32'(count_reg) + 32'd1) * 32'd4 > 32'(nb) * 32'd3) &&
                   (32'(nb) * 32'd2 <= 32'(MAX_BUCKETS));
    assign match = (r_rdata.len == len_reg) && (r_rdata.key == key_reg);

    always_comb
    begin
        for (int j = 0; j < 8; j++)
        begin
            key_m[j*8 +: 8] = (4'(j) < len_c) ? key_bytes[j*8 +: 8] : 8'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            count_reg     <= '0;
            lg_reg        <= LG_INIT;
            scan_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            lg_reg        <= lg_next;
            scan_reg      <= scan_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        key_reg        <= key_next;
        len_reg        <= len_next;
        hash_reg       <= hash_next;
        data_reg       <= data_next;
        start_reg      <= start_next;
        bkt_reg        <= bkt_next;
        cur_reg        <= cur_next;
        prev_reg       <= prev_next;
        idx_reg        <= idx_next;
        lrec_reg       <= lrec_next;
        lnext_reg      <= lnext_next;
        res_status_reg <= res_status_next;
        res_index_reg  <= res_index_next;
        res_value_reg  <= res_value_next;
        out_status_reg <= out_status_next;
        out_index_reg  <= out_index_next;
        out_value_reg  <= out_value_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        key_next        = key_reg;
        len_next        = len_reg;
        hash_next       = hash_reg;
        data_next       = data_reg;
        start_next      = start_reg;
        bkt_next        = bkt_reg;
        count_next      = count_reg;
        lg_next         = lg_reg;
        cur_next        = cur_reg;
        prev_next       = prev_reg;
        idx_next        = idx_reg;
        scan_next       = scan_reg;
        lrec_next       = lrec_reg;
        lnext_next      = lnext_reg;
        res_status_next = res_status_reg;
        res_index_next  = res_index_reg;
        res_value_next  = res_value_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_status_next = out_status_reg;
        out_index_next  = out_index_reg;
        out_value_next  = out_value_reg;

        h_we    = 1'b0;
        h_waddr = '0;
        h_wdata = NIL;
        h_raddr = '0;
        n_we    = 1'b0;
        n_waddr = '0;
        n_wdata = '0;
        n_raddr = '0;
        r_we    = 1'b0;
        r_waddr = '0;
        r_wdata = '0;
        r_raddr = '0;

        unique case (state_reg)
            S_CLEAR:
            begin
                h_we      = 1'b1;
                h_waddr   = scan_reg[BW-1:0];
                scan_next = scan_reg + SW'(1);
                if (scan_reg == SW'(MAX_BUCKETS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next   = cht_cmd_t'(command);
                    key_next   = key_m;
                    len_next   = len_c;
                    hash_next  = hash_value;
                    data_next  = data_value;
                    start_next = origin_bucket;
                    bkt_next   = hash_value[BW-1:0] & bmask;
                    state_next = S_START;
                end
            end
            S_START:
            begin
                unique case (cmd_reg)
                    CMD_INSERT:
                    begin
                        if (count_reg == PW'(ITEM_CAPACITY))
                        begin
                            res_status_next = STAT_FULL;
                            res_index_next  = '0;
                            res_value_next  = '0;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            h_raddr    = bkt_reg;
                            state_next = S_INS;
                        end
                    end
                    CMD_REMOVE, CMD_NEXT:
                    begin
                        h_raddr    = bkt_reg;
                        state_next = S_F_HEAD;
                    end
                    CMD_FIRST:
                    begin
                        scan_next  = SW'(start_reg);
                        state_next = S_FF_CHK;
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_INS:
            begin
                r_we            = 1'b1;
                r_waddr         = count_reg[IW-1:0];
                r_wdata.key     = key_reg;
                r_wdata.len     = len_reg;
                r_wdata.value   = data_reg;
                r_wdata.hash    = hash_reg;
                n_we            = 1'b1;
                n_waddr         = count_reg[IW-1:0];
                n_wdata         = h_rdata;
                h_we            = 1'b1;
                h_waddr         = bkt_reg;
                h_wdata         = count_reg;
                count_next      = count_reg + PW'(1);
                res_status_next = STAT_OK;
                res_index_next  = count_reg;
                res_value_next  = data_reg;
                if (grow)
                begin
                    lg_next    = lg_reg + LW'(1);
                    scan_next  = '0;
                    state_next = S_RH_CLR;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_RH_CLR:
            begin
                if (scan_reg < SW'(nb))
                begin
                    h_we      = 1'b1;
                    h_waddr   = scan_reg[BW-1:0];
                    scan_next = scan_reg + SW'(1);
                end
                else
                begin
                    cur_next   = '0;
                    state_next = S_RH_RD;
                end
            end
            S_RH_RD:
            begin
                if (cur_reg < count_reg)
                begin
                    r_raddr    = cur_reg[IW-1:0];
                    state_next = S_RH_HASH;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_RH_HASH:
            begin
                bkt_next   = r_rdata.hash[BW-1:0] & bmask;
                h_raddr    = r_rdata.hash[BW-1:0] & bmask;
                state_next = S_RH_LINK;
            end
            S_RH_LINK:
            begin
                n_we       = 1'b1;
                n_waddr    = cur_reg[IW-1:0];
                n_wdata    = h_rdata;
                h_we       = 1'b1;
                h_waddr    = bkt_reg;
                h_wdata    = cur_reg;
                cur_next   = cur_reg + PW'(1);
                state_next = S_RH_RD;
            end
            S_F_HEAD:
            begin
                cur_next   = h_rdata;
                prev_next  = NIL;
                state_next = S_F_CHK;
            end
            S_F_CHK:
            begin
                if (cur_reg < count_reg)
                begin
                    r_raddr    = cur_reg[IW-1:0];
                    n_raddr    = cur_reg[IW-1:0];
                    state_next = S_F_CMP;
                end
                else
                begin
                    res_status_next = STAT_MISS;
                    res_index_next  = '0;
                    res_value_next  = (cmd_reg == CMD_REMOVE) ? data_reg : 64'd0;
                    state_next      = S_DONE;
                end
            end
            S_F_CMP:
            begin
                if (!match)
                begin
                    prev_next  = cur_reg;
                    cur_next   = n_rdata;
                    state_next = S_F_CHK;
                end
                else if (cmd_reg == CMD_REMOVE)
                begin
                    res_status_next = STAT_OK;
                    res_index_next  = '0;
                    res_value_next  = r_rdata.value;
                    if (prev_reg == NIL)
                    begin
                        h_we    = 1'b1;
                        h_waddr = bkt_reg;
                        h_wdata = n_rdata;
                    end
                    else
                    begin
                        n_we    = 1'b1;
                        n_waddr = prev_reg[IW-1:0];
                        n_wdata = n_rdata;
                    end
                    idx_next   = cur_reg;
                    state_next = S_RM_LAST;
                end
                else if (n_rdata < count_reg)
                begin
                    cur_next   = n_rdata;
                    r_raddr    = n_rdata[IW-1:0];
                    state_next = S_VAL;
                end
                else
                begin
                    scan_next  = SW'(bkt_reg) + SW'(1);
                    state_next = S_FF_CHK;
                end
            end
            S_RM_LAST:
            begin
                if (idx_reg == last)
                begin
                    count_next = last;
                    state_next = S_DONE;
                end
                else
                begin
                    r_raddr    = last[IW-1:0];
                    n_raddr    = last[IW-1:0];
                    state_next = S_RM_LREC;
                end
            end
            S_RM_LREC:
            begin
                lrec_next  = r_rdata;
                lnext_next = n_rdata;
                bkt_next   = r_rdata.hash[BW-1:0] & bmask;
                h_raddr    = r_rdata.hash[BW-1:0] & bmask;
                state_next = S_RM_LHEAD;
            end
            S_RM_LHEAD:
            begin
                if (h_rdata == last)
                begin
                    h_we       = 1'b1;
                    h_waddr    = bkt_reg;
                    h_wdata    = idx_reg;
                    state_next = S_RM_COPY;
                end
                else
                begin
                    cur_next   = h_rdata;
                    state_next = S_RM_WCHK;
                end
            end
            S_RM_WCHK:
            begin
                if (cur_reg < count_reg)
                begin
                    n_raddr    = cur_reg[IW-1:0];
                    state_next = S_RM_WNXT;
                end
                else
                begin
                    state_next = S_RM_COPY;
                end
            end
            S_RM_WNXT:
            begin
                if (n_rdata == last)
                begin
                    n_we       = 1'b1;
                    n_waddr    = cur_reg[IW-1:0];
                    n_wdata    = idx_reg;
                    state_next = S_RM_COPY;
                end
                else
                begin
                    cur_next   = n_rdata;
                    state_next = S_RM_WCHK;
                end
            end
            S_RM_COPY:
            begin
                r_we       = 1'b1;
                r_waddr    = idx_reg[IW-1:0];
                r_wdata    = lrec_reg;
                n_we       = 1'b1;
                n_waddr    = idx_reg[IW-1:0];
                n_wdata    = lnext_reg;
                count_next = last;
                state_next = S_DONE;
            end
            S_FF_CHK:
            begin
                if (scan_reg < SW'(nb))
                begin
                    h_raddr    = scan_reg[BW-1:0];
                    state_next = S_FF_RD;
                end
                else
                begin
                    res_status_next = STAT_MISS;
                    res_index_next  = '0;
                    res_value_next  = '0;
                    state_next      = S_DONE;
                end
            end
            S_FF_RD:
            begin
                if (h_rdata < count_reg)
                begin
                    cur_next   = h_rdata;
                    r_raddr    = h_rdata[IW-1:0];
                    state_next = S_VAL;
                end
                else
                begin
                    scan_next  = scan_reg + SW'(1);
                    state_next = S_FF_CHK;
                end
            end
            S_VAL:
            begin
                res_status_next = STAT_OK;
                res_index_next  = cur_reg;
                res_value_next  = r_rdata.value;
                state_next      = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_index_next  = 8'(res_index_reg);
                    out_value_next  = res_value_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign in_stall     = (state_reg != S_IDLE);
    assign out_valid    = out_valid_reg;
    assign status       = out_status_reg;
    assign item_index   = out_index_reg;
    assign result_value = out_value_reg;

endmodule

/* design/cht_checker.sv */
// Port-level checks for the chained hash table engine, bound to the top level
`include "chained_hash_table_engine_core_macros.svh"

module cht_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [1:0]  status,
    input logic [7:0]  item_index,
    input logic [63:0] result_value
);

    import cht_pkg::*;

    `CHT_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall,
        out_valid && $stable(status) && $stable(item_index) && $stable(result_value))
    `CHT_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)
    `CHT_ASSERT_NOW(a_full_zero, clk, rst_n, out_valid && (status == STAT_FULL),
        (item_index == 8'd0) && (result_value == 64'd0))
    `CHT_ASSERT_NOW(a_miss_index, clk, rst_n, out_valid && (status == STAT_MISS),
        item_index == 8'd0)

endmodule

bind chained_hash_table_engine_core cht_checker u_cht_checker (.*);
